// ===== rtl/core/dai_pkg.sv =====
`default_nettype none

package dai_pkg;

    // Generic register file geometry: split into an even and an odd bank so that
    // a halfword pair (word, word + 1) always touches one entry of each bank.
    localparam int REG_WORDS  = 32;
    localparam int IDX_W      = $clog2(REG_WORDS);
    localparam int BANK_W     = IDX_W - 1;
    localparam int BANK_DEPTH = REG_WORDS / 2;

    // Field widths.
    localparam int MEM_W     = 27;
    localparam int DMA_LEN_W = 26;
    localparam int SRC_W     = 26;
    localparam int BLOCKS_W  = 15;

    // Item kinds.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BLOCK_PERIOD = 2'd0,
        CFG_DMA_POLLS    = 2'd1,
        CFG_MAIN_SIZE    = 2'd2,
        CFG_AUX_SIZE     = 2'd3
    } cfg_idx_t;

    // Register offsets.
    localparam logic [5:0] OFF_MBOX_LAST = 6'h06;
    localparam logic [5:0] OFF_CSR       = 6'h0A;
    localparam logic [5:0] OFF_MMADDR    = 6'h20;
    localparam logic [5:0] OFF_ARADDR    = 6'h24;
    localparam logic [5:0] OFF_CNT       = 6'h28;
    localparam logic [5:0] OFF_AID_HI    = 6'h30;
    localparam logic [5:0] OFF_AID_LO    = 6'h32;
    localparam logic [5:0] OFF_AID_CTRL  = 6'h36;
    localparam logic [5:0] OFF_AID_LEFT  = 6'h3A;

    // CSR and audio control fields.
    localparam logic [15:0] CTRL_MASK      = 16'h0C07;
    localparam logic [15:0] AID_LO_MASK    = 16'hFFE0;
    localparam int          AID_ENABLE_BIT = 15;
    localparam int          AUDIO_BLOCK_BYTES = 32;

    // Interrupt status and mask bits, as held internally (CSR bits 3 to 8).
    localparam int ST_AID_INT  = 0;
    localparam int ST_AR_INT   = 2;
    localparam int ST_DSP_INT  = 4;
    localparam logic [5:0] ST_INT_BITS  = 6'b010101;
    localparam logic [5:0] ST_MASK_BITS = 6'b101010;

    // Write request into the generic register file.
    typedef struct packed {
        logic [IDX_W-1:0] word;
        logic             hi_we;
        logic             lo_we;
        logic [15:0]      hi_data;
        logic [15:0]      lo_data;
    } rf_wr_t;

    // Read data from the generic register file.
    typedef struct packed {
        logic [15:0] hi;
        logic [15:0] lo;
        logic [31:0] main_addr;
        logic [31:0] aux_addr;
    } rf_rd_t;

    // One result item.
    typedef struct packed {
        logic [31:0]          read_data;
        logic                 int_line;
        logic                 audio_block_valid;
        logic [31:0]          audio_block_addr;
        logic                 control_write_valid;
        logic [15:0]          control_bits;
        logic                 dma_start;
        logic                 dma_copy_ok;
        logic [31:0]          dma_main_addr;
        logic [31:0]          dma_aux_addr;
        logic [DMA_LEN_W-1:0] dma_length;
        logic                 dma_to_aux;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dai_regfile.sv =====
`default_nettype none

module dai_regfile
    import dai_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_word,
    input  wire rf_wr_t           wr,
    output rf_rd_t                rd
);

    // Fixed bank entries that hold the aux DMA address pairs.
    localparam logic [BANK_W-1:0] MM_IDX = BANK_W'(OFF_MMADDR >> 2);
    localparam logic [BANK_W-1:0] AR_IDX = BANK_W'(OFF_ARADDR >> 2);

    logic [15:0]       even_reg [BANK_DEPTH];
    logic [15:0]       odd_reg  [BANK_DEPTH];
    logic [BANK_W-1:0] wr_hi_idx;
    logic [BANK_W-1:0] wr_lo_idx;
    logic [BANK_W-1:0] rd_hi_idx;
    logic [BANK_W-1:0] rd_lo_idx;

    // The upper halfword sits at word, the lower at word + 1 (wrapping).
    assign wr_hi_idx = wr.word[IDX_W-1:1];
    assign wr_lo_idx = wr.word[IDX_W-1:1] + BANK_W'(wr.word[0]);
    assign rd_hi_idx = rd_word[IDX_W-1:1];
    assign rd_lo_idx = rd_word[IDX_W-1:1] + BANK_W'(rd_word[0]);

    // Bank writes; the two halfwords of a pair always land in different banks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANK_DEPTH; i++)
            begin
                even_reg[i] <= '0;
                odd_reg[i]  <= '0;
            end
        end
        else
        begin
            if (wr.hi_we)
            begin
                if (wr.word[0])
                    odd_reg[wr_hi_idx] <= wr.hi_data;
                else
                    even_reg[wr_hi_idx] <= wr.hi_data;
            end
            if (wr.lo_we)
            begin
                if (wr.word[0])
                    even_reg[wr_lo_idx] <= wr.lo_data;
                else
                    odd_reg[wr_lo_idx] <= wr.lo_data;
            end
        end
    end

    // Read of the addressed pair and of the DMA address registers.
    always_comb
    begin
        rd.hi        = rd_word[0] ? odd_reg[rd_hi_idx] : even_reg[rd_hi_idx];
        rd.lo        = rd_word[0] ? even_reg[rd_lo_idx] : odd_reg[rd_lo_idx];
        rd.main_addr = {even_reg[MM_IDX], odd_reg[MM_IDX]};
        rd.aux_addr  = {even_reg[AR_IDX], odd_reg[AR_IDX]};
    end

endmodule

`default_nettype wire

// ===== rtl/core/dsp_interface_audio_dma_irq_unit.sv =====
`default_nettype none

// CPU-side register block of a DSP interface. Each item is a tick, a register
// read or a register write, and each item gives exactly one result item. The
// block holds the interrupt CSR (three write-1-to-clear status bits and their
// masks), the audio DMA pump that sends one 32-byte block address per period,
// the aux DMA kick with its poll-based completion, and a 32-entry generic
// halfword register file. An item is accepted in every cycle while the skid
// register is empty: all of its work is one pass of logic from the input
// ports and the state into a result register, backed by a one-entry skid
// register, so req_ready only drops when both hold results the consumer has
// not yet taken. The configuration port is always ready and should be written
// only while no item is in flight.
module dsp_interface_audio_dma_irq_unit
    import dai_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [MEM_W-1:0]     cfg_data,

    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic [1:0]           func,
    input  wire logic [5:0]           reg_offset,
    input  wire logic                 wide_access,
    input  wire logic [31:0]          write_data,
    input  wire logic [15:0]          tick_cycles,
    input  wire logic                 core_int_request,
    input  wire logic [15:0]          core_control,

    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [31:0]               read_data,
    output logic                      int_line,
    output logic                      audio_block_valid,
    output logic [31:0]               audio_block_addr,
    output logic                      control_write_valid,
    output logic [15:0]               control_bits,
    output logic                      dma_start,
    output logic                      dma_copy_ok,
    output logic [31:0]               dma_main_addr,
    output logic [31:0]               dma_aux_addr,
    output logic [DMA_LEN_W-1:0]      dma_length,
    output logic                      dma_to_aux
);

    // Configuration registers.
    logic [15:0]       period_reg;
    logic [7:0]        polls_cfg_reg;
    logic [MEM_W-1:0]  main_size_reg;
    logic [MEM_W-1:0]  aux_size_reg;

    // Block state.
    logic [5:0]          status_reg,  status_next;
    logic                busy_reg,    busy_next;
    logic [7:0]          polls_reg,   polls_next;
    logic [SRC_W-1:0]    src_reg,     src_next;
    logic [15:0]         actrl_reg,   actrl_next;
    logic [31:0]         cur_reg,     cur_next;
    logic [BLOCKS_W-1:0] rem_reg,     rem_next;
    logic [31:0]         accum_reg,   accum_next;
    logic                pending_reg, pending_next;

    // Result buffering.
    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    res_t res_next;

    // Decode and datapath temporaries.
    logic                req_fire;
    logic                is_mbox;
    logic                is_csr;
    logic                is_aid;
    logic [6:0]          off2;
    logic [15:0]         dh;
    logic [15:0]         dl;
    logic [15:0]         left_val;
    logic [31:0]         acc_sum;
    logic [32:0]         blk_end;
    logic [BLOCKS_W-1:0] rem_tmp;
    logic [31:0]         cur_tmp;
    logic                ctrl_we;
    logic [15:0]         ctrl_data;
    logic [DMA_LEN_W-1:0] dma_len;
    logic [32:0]         main_end;
    logic [32:0]         aux_end;
    logic [5:0]          csr_w6;
    rf_wr_t              rf_wr;
    rf_rd_t              rf_rd;

    // Read of one halfword in the audio register range.
    function automatic logic [15:0] aid_read16(
        input logic [6:0]       o,
        input logic [15:0]      gen,
        input logic [SRC_W-1:0] src,
        input logic [15:0]      ctrl,
        input logic [15:0]      left
    );
        logic [15:0] v;
        unique case (o)
            {1'b0, OFF_AID_HI}:   v = 16'(src[SRC_W-1:16]);
            {1'b0, OFF_AID_LO}:   v = src[15:0];
            {1'b0, OFF_AID_CTRL}: v = ctrl;
            {1'b0, OFF_AID_LEFT}: v = left;
            default:              v = gen;
        endcase
        return v;
    endfunction

    assign cfg_ready = 1'b1;
    assign req_ready = !skid_valid_reg;
    assign req_fire  = req_valid && req_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 16'd4096;
            polls_cfg_reg <= 8'd16;
            main_size_reg <= MEM_W'(25165824);
            aux_size_reg  <= MEM_W'(16777216);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLOCK_PERIOD: period_reg    <= cfg_data[15:0];
                CFG_DMA_POLLS:    polls_cfg_reg <= cfg_data[7:0];
                CFG_MAIN_SIZE:    main_size_reg <= cfg_data;
                CFG_AUX_SIZE:     aux_size_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Generic register file.
    dai_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_word (IDX_W'(reg_offset[5:1])),
        .wr      (rf_wr),
        .rd      (rf_rd)
    );

    // Address decode.
    assign is_mbox  = (reg_offset <= OFF_MBOX_LAST) && !reg_offset[0];
    assign is_csr   = (reg_offset == OFF_CSR);
    assign is_aid   = (reg_offset >= OFF_AID_HI) && (reg_offset <= OFF_AID_LEFT);
    assign off2     = {1'b0, reg_offset} + 7'd2;
    assign dh       = wide_access ? write_data[31:16] : write_data[15:0];
    assign dl       = write_data[15:0];
    assign left_val = (rem_reg != '0) ? 16'(rem_reg - 1'b1) : 16'd0;
    assign acc_sum  = accum_reg + 32'(tick_cycles);
    assign blk_end  = {1'b0, cur_reg} + 33'(AUDIO_BLOCK_BYTES);
    assign dma_len  = write_data[DMA_LEN_W-1:0];
    assign main_end = {1'b0, rf_rd.main_addr} + 33'(dma_len);
    assign aux_end  = {1'b0, rf_rd.aux_addr} + 33'(dma_len);
    assign csr_w6   = write_data[8:3];

    // Per-item work: state update and result.
    always_comb
    begin
        status_next  = status_reg;
        busy_next    = busy_reg;
        polls_next   = polls_reg;
        src_next     = src_reg;
        actrl_next   = actrl_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        accum_next   = accum_reg;
        pending_next = pending_reg;
        rem_tmp      = rem_reg;
        cur_tmp      = cur_reg;
        ctrl_we      = 1'b0;
        ctrl_data    = dh;
        res_next     = '0;
        rf_wr        = '0;
        rf_wr.word   = IDX_W'(reg_offset[5:1]);
        rf_wr.hi_data = dh;
        rf_wr.lo_data = dl;

        if (req_fire)
        begin
            if (core_int_request)
                status_next[ST_DSP_INT] = 1'b1;

            unique case (func_t'(func))
                FUNC_TICK:
                begin
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        status_next[ST_AID_INT] = 1'b1;
                    end
                    if (acc_sum < 32'(period_reg))
                        accum_next = acc_sum;
                    else
                    begin
                        accum_next = acc_sum - 32'(period_reg);
                        if (actrl_reg[AID_ENABLE_BIT])
                        begin
                            if (blk_end <= 33'(main_size_reg))
                            begin
                                res_next.audio_block_valid = 1'b1;
                                res_next.audio_block_addr  = cur_reg;
                            end
                            if (rem_reg != '0)
                            begin
                                rem_tmp = rem_reg - 1'b1;
                                cur_tmp = cur_reg + 32'(AUDIO_BLOCK_BYTES);
                            end
                            if (rem_tmp == '0)
                            begin
                                cur_next = 32'(src_reg);
                                rem_next = actrl_reg[BLOCKS_W-1:0];
                                status_next[ST_AID_INT] = 1'b1;
                            end
                            else
                            begin
                                cur_next = cur_tmp;
                                rem_next = rem_tmp;
                            end
                        end
                    end
                end

                FUNC_READ:
                begin
                    priority if (is_mbox)
                        res_next.read_data = '0;
                    else if (is_csr)
                    begin
                        res_next.read_data = 32'({6'b0, busy_reg, status_next, 3'b0}
                                                 | (core_control & CTRL_MASK));
                        // Each CSR read counts down a busy aux DMA.
                        if (busy_reg)
                        begin
                            polls_next = polls_reg - 8'd1;
                            if (polls_next == 8'd0)
                            begin
                                busy_next = 1'b0;
                                status_next[ST_AR_INT] = 1'b1;
                            end
                        end
                    end
                    else if (is_aid)
                    begin
                        if (wide_access)
                            res_next.read_data = {
                                aid_read16({1'b0, reg_offset}, rf_rd.hi, src_reg,
                                           actrl_reg, left_val),
                                aid_read16(off2, rf_rd.lo, src_reg, actrl_reg, left_val)};
                        else
                            res_next.read_data = {16'b0,
                                aid_read16({1'b0, reg_offset}, rf_rd.hi, src_reg,
                                           actrl_reg, left_val)};
                    end
                    else
                        res_next.read_data = wide_access ? {rf_rd.hi, rf_rd.lo}
                                                         : {16'b0, rf_rd.hi};
                end

                FUNC_WRITE:
                begin
                    priority if (is_mbox)
                        status_next = status_next;
                    else if (is_csr)
                    begin
                        res_next.control_write_valid = 1'b1;
                        res_next.control_bits = write_data[15:0] & CTRL_MASK;
                        // Status bits clear on 1; masks take the written value.
                        status_next = (status_next & ~(csr_w6 & ST_INT_BITS) & ~ST_MASK_BITS)
                                    | (csr_w6 & ST_MASK_BITS);
                    end
                    else if (is_aid)
                    begin
                        // Halfword at the item's offset.
                        unique case (reg_offset)
                            OFF_AID_HI:   src_next[SRC_W-1:16] = dh[SRC_W-17:0];
                            OFF_AID_LO:   src_next[15:0] = dh & AID_LO_MASK;
                            OFF_AID_CTRL:
                            begin
                                ctrl_we   = 1'b1;
                                ctrl_data = dh;
                            end
                            OFF_AID_LEFT: ;
                            default:      rf_wr.hi_we = 1'b1;
                        endcase
                        // Second halfword of a wide write.
                        if (wide_access)
                        begin
                            unique case (off2)
                                {1'b0, OFF_AID_LO}: src_next[15:0] = dl & AID_LO_MASK;
                                {1'b0, OFF_AID_CTRL}:
                                begin
                                    ctrl_we   = 1'b1;
                                    ctrl_data = dl;
                                end
                                {1'b0, OFF_AID_LEFT}: ;
                                default: rf_wr.lo_we = 1'b1;
                            endcase
                        end
                        // Enabling the pump reloads it and raises the interrupt next tick.
                        if (ctrl_we)
                        begin
                            actrl_next = ctrl_data;
                            if (!actrl_reg[AID_ENABLE_BIT] && ctrl_data[AID_ENABLE_BIT])
                            begin
                                cur_next     = 32'(src_reg);
                                rem_next     = ctrl_data[BLOCKS_W-1:0];
                                pending_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        rf_wr.hi_we = 1'b1;
                        rf_wr.lo_we = wide_access;
                        // A write to the count register kicks the aux DMA.
                        if (reg_offset == OFF_CNT)
                        begin
                            res_next.dma_start     = 1'b1;
                            res_next.dma_copy_ok   = (dma_len != '0)
                                                  && (main_end <= 33'(main_size_reg))
                                                  && (aux_end <= 33'(aux_size_reg));
                            res_next.dma_main_addr = rf_rd.main_addr;
                            res_next.dma_aux_addr  = rf_rd.aux_addr;
                            res_next.dma_length    = dma_len;
                            res_next.dma_to_aux    = !write_data[31];
                            busy_next  = 1'b1;
                            polls_next = polls_cfg_reg;
                        end
                    end
                end

                default: ;
            endcase
        end

        res_next.int_line = |(status_next & {1'b0, status_next[5:1]} & ST_INT_BITS);
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= '0;
            busy_reg    <= 1'b0;
            polls_reg   <= '0;
            src_reg     <= '0;
            actrl_reg   <= '0;
            cur_reg     <= '0;
            rem_reg     <= '0;
            accum_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            status_reg  <= status_next;
            busy_reg    <= busy_next;
            polls_reg   <= polls_next;
            src_reg     <= src_next;
            actrl_reg   <= actrl_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
            accum_reg   <= accum_next;
            pending_reg <= pending_next;
        end
    end

    // Output register and skid register valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (rsp_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            if (!out_valid_reg || rsp_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rsp_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (req_fire)
        begin
            if (!out_valid_reg || rsp_ready)
                out_data_reg <= res_next;
            else
                skid_data_reg <= res_next;
        end
    end

    assign rsp_valid           = out_valid_reg;
    assign read_data           = out_data_reg.read_data;
    assign int_line            = out_data_reg.int_line;
    assign audio_block_valid   = out_data_reg.audio_block_valid;
    assign audio_block_addr    = out_data_reg.audio_block_addr;
    assign control_write_valid = out_data_reg.control_write_valid;
    assign control_bits        = out_data_reg.control_bits;
    assign dma_start           = out_data_reg.dma_start;
    assign dma_copy_ok         = out_data_reg.dma_copy_ok;
    assign dma_main_addr       = out_data_reg.dma_main_addr;
    assign dma_aux_addr        = out_data_reg.dma_aux_addr;
    assign dma_length          = out_data_reg.dma_length;
    assign dma_to_aux          = out_data_reg.dma_to_aux;

endmodule

`default_nettype wire

// ===== test/dsp_interface_audio_dma_irq_unit_tb.sv =====
module dsp_interface_audio_dma_irq_unit_tb;
    import dai_pkg::*;

    // Item kind that only latches the core interrupt request.
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // Offsets used by the directed tests beyond those of the package.
    localparam logic [5:0] OFF_MBOX_FIRST = 6'h00;
    localparam logic [5:0] OFF_AID_GEN    = 6'h34;
    localparam logic [5:0] OFF_GEN_LAST   = 6'h3E;

    // CSR write values: set all masks and clear no status, or clear all status and set all masks.
    localparam logic [31:0] CSR_SET_MASKS = 32'hFFFF_FF57;
    localparam logic [31:0] CSR_CLEAR_ALL = 32'hFFFF_FFFF;

    // Audio control fields.
    localparam logic [15:0] AID_ON_TWO_BLOCKS = 16'h8002;

    // Configuration values.
    localparam logic [15:0]      PERIOD_DEFAULT = 16'd4096;
    localparam logic [15:0]      PERIOD_MAX     = 16'hFFFF;
    localparam logic [7:0]       POLLS_DEFAULT  = 8'd16;
    localparam logic [7:0]       POLLS_MAX      = 8'hFF;
    localparam logic [MEM_W-1:0] MAIN_DEFAULT   = 27'h180_0000;
    localparam logic [MEM_W-1:0] AUX_DEFAULT    = 27'h100_0000;
    localparam logic [MEM_W-1:0] MEM_SIZE_MAX   = 27'h400_0000;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS  = 60;

    // One bus item as offered to the block.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  reg_off;
        logic        wide;
        logic [31:0] wdata;
        logic [15:0] cycles;
        logic        core_req;
        logic [15:0] core_ctrl;
    } cpu_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [MEM_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_ready;
    logic [1:0]           func;
    logic [5:0]           reg_offset;
    logic                 wide_access;
    logic [31:0]          write_data;
    logic [15:0]          tick_cycles;
    logic                 core_int_request;
    logic [15:0]          core_control;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic [31:0]          read_data;
    logic                 int_line;
    logic                 audio_block_valid;
    logic [31:0]          audio_block_addr;
    logic                 control_write_valid;
    logic [15:0]          control_bits;
    logic                 dma_start;
    logic                 dma_copy_ok;
    logic [31:0]          dma_main_addr;
    logic [31:0]          dma_aux_addr;
    logic [DMA_LEN_W-1:0] dma_length;
    logic                 dma_to_aux;

    // Shadow copy of the block state and its configuration.
    logic [5:0]           st_flags;
    logic                 aux_busy;
    logic [7:0]           polls_left;
    logic [SRC_W-1:0]     aud_src;
    logic [15:0]          aud_ctrl;
    logic [31:0]          aud_addr;
    logic [BLOCKS_W-1:0]  aud_blocks;
    logic [31:0]          aud_accum;
    logic                 aud_start_pend;
    logic [15:0]          gen_file [REG_WORDS];
    logic [15:0]          cfg_period;
    logic [7:0]           cfg_polls;
    logic [MEM_W-1:0]     cfg_main_size;
    logic [MEM_W-1:0]     cfg_aux_size;

    res_t                 pending_bus_results [$];
    res_t                 want;
    int                   error_count;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   rsp_stall_pct;
    int                   rsp_hold_left;

    dsp_interface_audio_dma_irq_unit i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .func                (func),
        .reg_offset          (reg_offset),
        .wide_access         (wide_access),
        .write_data          (write_data),
        .tick_cycles         (tick_cycles),
        .core_int_request    (core_int_request),
        .core_control        (core_control),
        .rsp_valid           (rsp_valid),
        .rsp_ready           (rsp_ready),
        .read_data           (read_data),
        .int_line            (int_line),
        .audio_block_valid   (audio_block_valid),
        .audio_block_addr    (audio_block_addr),
        .control_write_valid (control_write_valid),
        .control_bits        (control_bits),
        .dma_start           (dma_start),
        .dma_copy_ok         (dma_copy_ok),
        .dma_main_addr       (dma_main_addr),
        .dma_aux_addr        (dma_aux_addr),
        .dma_length          (dma_length),
        .dma_to_aux          (dma_to_aux)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Two halfwords of the generic file, the second index wrapping.
    function automatic logic [31:0] gen_pair(input logic [IDX_W-1:0] word);
        logic [IDX_W-1:0] nxt;
        nxt = word + 1'b1;
        return {gen_file[word], gen_file[nxt]};
    endfunction

    // One halfword read in the audio range.
    function automatic logic [15:0] audio_reg_read(input logic [5:0] off);
        case (off)
            OFF_AID_HI:   return 16'(aud_src[SRC_W-1:16]);
            OFF_AID_LO:   return aud_src[15:0];
            OFF_AID_CTRL: return aud_ctrl;
            OFF_AID_LEFT: return (aud_blocks != '0) ? 16'(aud_blocks - 1'b1) : 16'h0000;
            default:      return gen_file[off[5:1]];
        endcase
    endfunction

    // One halfword write in the audio range; enabling the pump restarts it.
    function automatic void audio_reg_write(input logic [5:0] off, input logic [15:0] v);
        case (off)
            OFF_AID_HI:
            begin
                aud_src[SRC_W-1:16] = v[SRC_W-17:0];
            end
            OFF_AID_LO:
            begin
                aud_src[15:0] = v & AID_LO_MASK;
            end
            OFF_AID_CTRL:
            begin
                if (!aud_ctrl[AID_ENABLE_BIT] && v[AID_ENABLE_BIT])
                begin
                    aud_addr = 32'(aud_src);
                    aud_blocks = v[BLOCKS_W-1:0];
                    aud_start_pend = 1'b1;
                end
                aud_ctrl = v;
            end
            OFF_AID_LEFT:
            begin
            end
            default:
            begin
                gen_file[off[5:1]] = v;
            end
        endcase
    endfunction

    // Works out the result of one accepted item and advances the shadow state.
    function automatic res_t compute_bus_result(input cpu_item_t it);
        res_t             r;
        logic [IDX_W-1:0] word;
        logic [IDX_W-1:0] nxt;
        logic [5:0]       w6;
        logic [31:0]      mm;
        logic [31:0]      ar;
        logic [25:0]      len;
        logic             mailbox;
        logic             aid_range;
        r = '0;
        word = it.reg_off[5:1];
        nxt = word + 1'b1;
        mailbox = (it.reg_off <= OFF_MBOX_LAST) && !it.reg_off[0];
        aid_range = (it.reg_off >= OFF_AID_HI) && (it.reg_off <= OFF_AID_LEFT);
        if (it.core_req)
            st_flags[ST_DSP_INT] = 1'b1;
        case (it.kind)
            FUNC_TICK:
            begin
                // A pending start raises the audio interrupt on the next tick.
                if (aud_start_pend)
                begin
                    aud_start_pend = 1'b0;
                    st_flags[ST_AID_INT] = 1'b1;
                end
                aud_accum = aud_accum + 32'(it.cycles);
                if (aud_accum >= 32'(cfg_period))
                begin
                    aud_accum = aud_accum - 32'(cfg_period);
                    if (aud_ctrl[AID_ENABLE_BIT])
                    begin
                        if (33'(aud_addr) + 33'(AUDIO_BLOCK_BYTES) <= 33'(cfg_main_size))
                        begin
                            r.audio_block_valid = 1'b1;
                            r.audio_block_addr = aud_addr;
                        end
                        if (aud_blocks != '0)
                        begin
                            aud_blocks = aud_blocks - 1'b1;
                            aud_addr = aud_addr + 32'(AUDIO_BLOCK_BYTES);
                        end
                        if (aud_blocks == '0)
                        begin
                            aud_addr = 32'(aud_src);
                            aud_blocks = aud_ctrl[BLOCKS_W-1:0];
                            st_flags[ST_AID_INT] = 1'b1;
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                if (mailbox)
                begin
                    r.read_data = '0;
                end
                else if (it.reg_off == OFF_CSR)
                begin
                    // Each status read counts down a busy aux DMA.
                    r.read_data = 32'({aux_busy, st_flags, 3'b000}) |
                                  32'(it.core_ctrl & CTRL_MASK);
                    if (aux_busy)
                    begin
                        polls_left = polls_left - 1'b1;
                        if (polls_left == '0)
                        begin
                            aux_busy = 1'b0;
                            st_flags[ST_AR_INT] = 1'b1;
                        end
                    end
                end
                else if (aid_range)
                begin
                    if (it.wide)
                        r.read_data = {audio_reg_read(it.reg_off),
                                       audio_reg_read(it.reg_off + 6'd2)};
                    else
                        r.read_data = 32'(audio_reg_read(it.reg_off));
                end
                else
                begin
                    r.read_data = it.wide ? gen_pair(word) : 32'(gen_file[word]);
                end
            end
            FUNC_WRITE:
            begin
                if (mailbox)
                begin
                end
                else if (it.reg_off == OFF_CSR)
                begin
                    // Status bits clear on one, masks take the written value.
                    w6 = it.wdata[8:3];
                    r.control_write_valid = 1'b1;
                    r.control_bits = it.wdata[15:0] & CTRL_MASK;
                    st_flags = st_flags & ~(w6 & ST_INT_BITS);
                    st_flags = (st_flags & ~ST_MASK_BITS) | (w6 & ST_MASK_BITS);
                end
                else if (aid_range)
                begin
                    if (it.wide)
                    begin
                        audio_reg_write(it.reg_off, it.wdata[31:16]);
                        audio_reg_write(it.reg_off + 6'd2, it.wdata[15:0]);
                    end
                    else
                    begin
                        audio_reg_write(it.reg_off, it.wdata[15:0]);
                    end
                end
                else
                begin
                    if (it.wide)
                    begin
                        gen_file[word] = it.wdata[31:16];
                        gen_file[nxt] = it.wdata[15:0];
                    end
                    else
                    begin
                        gen_file[word] = it.wdata[15:0];
                    end
                    // A write to the count register kicks the aux DMA.
                    if (it.reg_off == OFF_CNT)
                    begin
                        mm = gen_pair(OFF_MMADDR[5:1]);
                        ar = gen_pair(OFF_ARADDR[5:1]);
                        len = it.wdata[25:0];
                        r.dma_start = 1'b1;
                        r.dma_copy_ok = (len != '0) &&
                                        (33'(mm) + 33'(len) <= 33'(cfg_main_size)) &&
                                        (33'(ar) + 33'(len) <= 33'(cfg_aux_size));
                        r.dma_main_addr = mm;
                        r.dma_aux_addr = ar;
                        r.dma_length = len;
                        r.dma_to_aux = !it.wdata[31];
                        aux_busy = 1'b1;
                        polls_left = cfg_polls;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.int_line = |(st_flags & (st_flags >> 1) & ST_INT_BITS);
        return r;
    endfunction

    function automatic cpu_item_t make_item(input logic [1:0] kind, input logic [5:0] off,
                                            input logic wide, input logic [31:0] data,
                                            input logic [15:0] cyc, input logic req);
        cpu_item_t it;
        it.kind = kind;
        it.reg_off = off;
        it.wide = wide;
        it.wdata = data;
        it.cycles = cyc;
        it.core_req = req;
        it.core_ctrl = 16'($urandom);
        return it;
    endfunction

    // Mostly well-formed register traffic with random content, some noise.
    function automatic cpu_item_t random_bus_item();
        cpu_item_t   it;
        int unsigned pick;
        int unsigned span;
        it = make_item(FUNC_NOP, 6'($urandom_range(63)), 1'($urandom), $urandom,
                       16'($urandom), ($urandom_range(99) < 8));
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            it.kind = FUNC_TICK;
            span = 2 * int'(cfg_period);
            if ($urandom_range(3) != 0)
                it.cycles = (span > 65535) ? 16'($urandom) : 16'($urandom_range(span));
        end
        else if (pick < 60)
        begin
            it.kind = FUNC_READ;
            case ($urandom_range(5))
                0, 1:    it.reg_off = OFF_CSR;
                2:       it.reg_off = OFF_AID_LEFT;
                3:       it.reg_off = 6'($urandom_range(OFF_AID_HI, OFF_AID_LEFT));
                default: it.reg_off = it.reg_off;
            endcase
        end
        else if (pick < 95)
        begin
            it.kind = FUNC_WRITE;
            case ($urandom_range(9))
                0:
                begin
                    it.reg_off = OFF_CSR;
                end
                1:
                begin
                    it.reg_off = OFF_AID_HI;
                    it.wide = 1'b1;
                    if ($urandom_range(3) != 0)
                        it.wdata[31:16] = 16'($urandom_range(16'h0180));
                end
                2, 3:
                begin
                    it.reg_off = OFF_AID_CTRL;
                    it.wide = 1'b0;
                    if ($urandom_range(3) != 0)
                        it.wdata[14:0] = 15'($urandom_range(6));
                end
                4, 5:
                begin
                    it.reg_off = ($urandom_range(1) != 0) ? OFF_MMADDR : OFF_ARADDR;
                    it.wide = 1'b1;
                    if ($urandom_range(3) != 0)
                        it.wdata = $urandom_range(32'h01FF_FFFF);
                end
                6, 7:
                begin
                    it.reg_off = OFF_CNT;
                    if ($urandom_range(7) == 0)
                        it.wdata[25:0] = '0;
                    else if ($urandom_range(3) != 0)
                        it.wdata[25:0] = 26'($urandom_range(32'h0040_0000));
                end
                default:
                begin
                    it.reg_off = it.reg_off;
                end
            endcase
        end
        return it;
    endfunction

    // Offer one item, idling at random before it, and record its result.
    task automatic send_item(input cpu_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        func = it.kind;
        reg_offset = it.reg_off;
        wide_access = it.wide;
        write_data = it.wdata;
        tick_cycles = it.cycles;
        core_int_request = it.core_req;
        core_control = it.core_ctrl;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_bus_results.push_back(compute_bus_result(it));
    endtask

    task automatic do_write(input logic [5:0] off, input logic wide, input logic [31:0] data);
        send_item(make_item(FUNC_WRITE, off, wide, data, 16'($urandom), 1'b0));
    endtask

    task automatic do_read(input logic [5:0] off, input logic wide);
        send_item(make_item(FUNC_READ, off, wide, $urandom, 16'($urandom), 1'b0));
    endtask

    task automatic do_tick(input logic [15:0] cyc);
        send_item(make_item(FUNC_TICK, 6'($urandom), 1'($urandom), $urandom, cyc, 1'b0));
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input cfg_idx_t idx, input logic [MEM_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BLOCK_PERIOD: cfg_period = value[15:0];
            CFG_DMA_POLLS:    cfg_polls = value[7:0];
            CFG_MAIN_SIZE:    cfg_main_size = value;
            CFG_AUX_SIZE:     cfg_aux_size = value;
            default:          cfg_period = cfg_period;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reprogram all four registers once the block has gone idle.
    task automatic set_config(input logic [15:0] period, input logic [7:0] polls,
                              input logic [MEM_W-1:0] main_size,
                              input logic [MEM_W-1:0] aux_size);
        drain_results();
        write_config(CFG_BLOCK_PERIOD, MEM_W'(period));
        write_config(CFG_DMA_POLLS, MEM_W'(polls));
        write_config(CFG_MAIN_SIZE, main_size);
        write_config(CFG_AUX_SIZE, aux_size);
    endtask

    // Status register, interrupt latch, masks and mailbox decode.
    task automatic test_csr_and_mailboxes();
        do_read(OFF_CSR, 1'b0);
        send_item(make_item(FUNC_NOP, OFF_CSR, 1'b1, CSR_CLEAR_ALL, 16'hFFFF, 1'b1));
        do_write(OFF_CSR, 1'b0, CSR_SET_MASKS);
        do_read(OFF_CSR, 1'b1);
        do_write(OFF_CSR, 1'b1, CSR_CLEAR_ALL);
        do_write(OFF_MBOX_FIRST, 1'b1, CSR_CLEAR_ALL);
        do_read(OFF_MBOX_LAST, 1'b1);
    endtask

    // Generic file: wrap of wide accesses and odd offsets.
    task automatic test_generic_file();
        do_write(OFF_GEN_LAST, 1'b1, 32'hFFFF_FFFF);
        do_read(OFF_GEN_LAST + 6'd1, 1'b1);
        do_read(OFF_MBOX_FIRST + 6'd1, 1'b1);
        do_write(OFF_CSR + 6'd1, 1'b0, 32'h0000_0000);
    endtask

    // Audio pump start, block emission, reload and the blocks-left register.
    task automatic test_audio_pump();
        do_write(OFF_AID_HI, 1'b1, 32'h0000_1000);
        do_write(OFF_AID_CTRL, 1'b0, 32'(AID_ON_TWO_BLOCKS));
        do_read(OFF_AID_LEFT, 1'b1);
        do_tick(16'h0000);
        do_tick(PERIOD_DEFAULT);
        do_tick(16'hFFFF);
        do_write(OFF_AID_LEFT, 1'b0, 32'hFFFF_FFFF);
        do_read(OFF_AID_GEN, 1'b1);
        do_write(OFF_AID_CTRL, 1'b0, 32'h0000_0000);
    endtask

    // Aux DMA kicks: in bounds, too long, zero length, then a status poll.
    task automatic test_aux_dma();
        do_write(OFF_MMADDR, 1'b1, 32'h0000_0100);
        do_write(OFF_ARADDR, 1'b1, 32'h0000_0200);
        do_write(OFF_CNT, 1'b0, 32'h8000_0040);
        do_write(OFF_CNT, 1'b1, 32'h03FF_FFFF);
        do_write(OFF_CNT, 1'b0, 32'h0000_0000);
        do_read(OFF_CSR, 1'b0);
    endtask

    // A poll count of zero wraps, so the DMA stays busy for 256 status reads.
    task automatic test_poll_count_wrap();
        int k;
        set_config(16'd1, 8'd0, '0, '0);
        do_write(OFF_CNT, 1'b0, 32'h0000_0010);
        for (k = 0; k < 262; k++)
        begin
            if (k % 50 == 0)
                do_tick(16'($urandom_range(3)));
            send_item(make_item(FUNC_READ, OFF_CSR, 1'($urandom), $urandom, 16'($urandom),
                                ($urandom_range(99) < 5)));
        end
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        int k;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
            send_item(random_bus_item());
    endtask

    // The receiver holds off while items keep coming, so the input must stall.
    task automatic test_receiver_holdoff();
        int k;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        rsp_hold_left = 80;
        for (k = 0; k < 150; k++)
            send_item(random_bus_item());
    endtask

    // Result acceptance on the output side.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_ready = 1'b0;
                rsp_hold_left--;
            end
            else
            begin
                rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            if (error_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_bus_results.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: result item with none expected, expected none, actual 0x%08h",
                             $time, read_data);
                error_count++;
            end
            else
            begin
                want = pending_bus_results.pop_front();
                check_field("read_data", want.read_data, read_data);
                check_field("int_line", 32'(want.int_line), 32'(int_line));
                check_field("audio_block_valid", 32'(want.audio_block_valid),
                            32'(audio_block_valid));
                check_field("audio_block_addr", want.audio_block_addr, audio_block_addr);
                check_field("control_write_valid", 32'(want.control_write_valid),
                            32'(control_write_valid));
                check_field("control_bits", 32'(want.control_bits), 32'(control_bits));
                check_field("dma_start", 32'(want.dma_start), 32'(dma_start));
                check_field("dma_copy_ok", 32'(want.dma_copy_ok), 32'(dma_copy_ok));
                check_field("dma_main_addr", want.dma_main_addr, dma_main_addr);
                check_field("dma_aux_addr", want.dma_aux_addr, dma_aux_addr);
                check_field("dma_length", 32'(want.dma_length), 32'(dma_length));
                check_field("dma_to_aux", 32'(want.dma_to_aux), 32'(dma_to_aux));
            end
        end
    end

    initial
    begin
        // Known values on every input and the reset state of the shadow copy.
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BLOCK_PERIOD;
        cfg_data = '0;
        req_valid = 1'b0;
        func = FUNC_TICK;
        reg_offset = '0;
        wide_access = 1'b0;
        write_data = '0;
        tick_cycles = '0;
        core_int_request = 1'b0;
        core_control = '0;
        error_count = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        rsp_hold_left = 0;
        st_flags = '0;
        aux_busy = 1'b0;
        polls_left = '0;
        aud_src = '0;
        aud_ctrl = '0;
        aud_addr = '0;
        aud_blocks = '0;
        aud_accum = '0;
        aud_start_pend = 1'b0;
        foreach (gen_file[i])
            gen_file[i] = '0;
        cfg_period = PERIOD_DEFAULT;
        cfg_polls = POLLS_DEFAULT;
        cfg_main_size = MAIN_DEFAULT;
        cfg_aux_size = AUX_DEFAULT;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_csr_and_mailboxes();
        test_generic_file();
        test_audio_pump();
        test_aux_dma();
        test_poll_count_wrap();

        set_config(16'd1, 8'd1, '0, '0);
        test_random_traffic(300, 0, 0);
        set_config(PERIOD_MAX, POLLS_MAX, MEM_SIZE_MAX, MEM_SIZE_MAX);
        test_random_traffic(400, 51, 0);
        set_config(16'($urandom_range(16, 8192)), 8'($urandom_range(1, 40)),
                   MEM_W'($urandom_range(MEM_SIZE_MAX)), MEM_W'($urandom_range(MEM_SIZE_MAX)));
        test_random_traffic(400, 0, 51);
        set_config(16'd64, 8'd4, MAIN_DEFAULT, AUX_DEFAULT);
        test_random_traffic(400, 24, 24);
        test_receiver_holdoff();
        set_config(PERIOD_DEFAULT, POLLS_DEFAULT, MAIN_DEFAULT, AUX_DEFAULT);
        test_random_traffic(100, 0, 0);
        drain_results();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dai_pkg.sv
rtl/core/dai_regfile.sv
rtl/core/dsp_interface_audio_dma_irq_unit.sv
test/dsp_interface_audio_dma_irq_unit_tb.sv
